// File: hdl/wsm_pkg.sv
// Shared constants, types and helper functions of the stack machine step core.
package wsm_pkg;

    localparam int STACK_DEPTH  = 256;
    localparam int LABEL_DEPTH  = 32;
    localparam int LOCAL_COUNT  = 64;
    localparam int GLOBAL_COUNT = 16;
    localparam int MEMORY_BYTES = 65536;

    localparam int PC_W  = 17;
    localparam int ST_W  = 3;
    localparam int CMD_W = 8;
    localparam int IMM_W = 64;
    localparam int VAL_W = 64;
    localparam int CFG_W = 17;
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int LSP_W = $clog2(LABEL_DEPTH + 1);
    localparam int LA_W  = $clog2(LABEL_DEPTH);
    localparam int LI_W  = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
    localparam int GI_W  = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;
    localparam int MA_W  = $clog2(MEMORY_BYTES);
    localparam int LIM_W = (MA_W + 1 > CFG_W) ? MA_W + 1 : CFG_W;

    localparam int IN_RAW  = CMD_W + IMM_W;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = PC_W + ST_W + VAL_W + SP_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [ST_W-1:0] STAT_RUN   = 3'd0;
    localparam logic [ST_W-1:0] STAT_DONE  = 3'd1;
    localparam logic [ST_W-1:0] STAT_MEM   = 3'd2;
    localparam logic [ST_W-1:0] STAT_UNK   = 3'd3;
    localparam logic [ST_W-1:0] STAT_DIV   = 3'd4;
    localparam logic [ST_W-1:0] STAT_STACK = 3'd5;

    localparam logic CFG_CODE_LENGTH = 1'b0;
    localparam logic CFG_MEMORY_SIZE = 1'b1;

    localparam logic [7:0] OP_BLOCK      = 8'h02;
    localparam logic [7:0] OP_LOOP       = 8'h03;
    localparam logic [7:0] OP_IF         = 8'h04;
    localparam logic [7:0] OP_END        = 8'h0B;
    localparam logic [7:0] OP_BR         = 8'h0C;
    localparam logic [7:0] OP_BR_IF      = 8'h0D;
    localparam logic [7:0] OP_DROP       = 8'h1A;
    localparam logic [7:0] OP_SELECT     = 8'h1B;
    localparam logic [7:0] OP_LOCAL_GET  = 8'h20;
    localparam logic [7:0] OP_LOCAL_SET  = 8'h21;
    localparam logic [7:0] OP_LOCAL_TEE  = 8'h22;
    localparam logic [7:0] OP_GLOBAL_GET = 8'h23;
    localparam logic [7:0] OP_GLOBAL_SET = 8'h24;
    localparam logic [7:0] OP_LOAD32     = 8'h28;
    localparam logic [7:0] OP_LOAD8_S    = 8'h2C;
    localparam logic [7:0] OP_LOAD8_U    = 8'h2D;
    localparam logic [7:0] OP_STORE32    = 8'h36;
    localparam logic [7:0] OP_STORE8     = 8'h3A;
    localparam logic [7:0] OP_I32_CONST  = 8'h41;
    localparam logic [7:0] OP_I64_CONST  = 8'h42;
    localparam logic [7:0] OP_EQZ        = 8'h45;
    localparam logic [7:0] OP_EQ         = 8'h46;
    localparam logic [7:0] OP_NE         = 8'h47;
    localparam logic [7:0] OP_LT_S       = 8'h48;
    localparam logic [7:0] OP_LT_U       = 8'h49;
    localparam logic [7:0] OP_GT_S       = 8'h4A;
    localparam logic [7:0] OP_GT_U       = 8'h4B;
    localparam logic [7:0] OP_LE_S       = 8'h4C;
    localparam logic [7:0] OP_LE_U       = 8'h4D;
    localparam logic [7:0] OP_ADD        = 8'h6A;
    localparam logic [7:0] OP_SUB        = 8'h6B;
    localparam logic [7:0] OP_MUL        = 8'h6C;
    localparam logic [7:0] OP_DIV_S      = 8'h6D;
    localparam logic [7:0] OP_REM_S      = 8'h6F;
    localparam logic [7:0] OP_AND        = 8'h71;
    localparam logic [7:0] OP_OR         = 8'h72;
    localparam logic [7:0] OP_SHL        = 8'h74;
    localparam logic [7:0] OP_SHR_S      = 8'h75;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDB,
        S_EXEC,
        S_DIV,
        S_MEM
    } state_t;

    typedef struct packed {
        logic       known;
        logic [1:0] pops;
        logic       pushes;
    } shape_t;

    typedef struct packed {
        logic [PC_W-1:0]  pc;
        logic [ST_W-1:0]  st;
        logic [SP_W-1:0]  sp;
        logic [LSP_W-1:0] lsp;
        logic             push;
        logic [VAL_W-1:0] res;
        logic [VAL_W-1:0] top;
        logic             halt;
    } commit_t;

    function automatic logic [VAL_W-1:0] sx32(input logic [31:0] v);
        return {{(VAL_W-32){v[31]}}, v};
    endfunction

    function automatic shape_t op_shape(input logic [7:0] op);
        shape_t s;
        s = '{known: 1'b1, pops: 2'd0, pushes: 1'b0};
        case (op)
            OP_I32_CONST, OP_I64_CONST, OP_LOCAL_GET, OP_GLOBAL_GET: s.pushes = 1'b1;
            OP_LOCAL_SET, OP_GLOBAL_SET, OP_IF, OP_BR_IF, OP_DROP: s.pops = 2'd1;
            OP_LOCAL_TEE, OP_EQZ, OP_LOAD32, OP_LOAD8_S, OP_LOAD8_U: begin
                s.pops = 2'd1;
                s.pushes = 1'b1;
            end
            OP_EQ, OP_NE, OP_LT_S, OP_LT_U, OP_GT_S, OP_GT_U, OP_LE_S, OP_LE_U,
            OP_ADD, OP_SUB, OP_MUL, OP_DIV_S, OP_REM_S, OP_AND, OP_OR,
            OP_SHL, OP_SHR_S: begin
                s.pops = 2'd2;
                s.pushes = 1'b1;
            end
            OP_STORE32, OP_STORE8: s.pops = 2'd2;
            OP_BLOCK, OP_LOOP, OP_END, OP_BR: s.pops = 2'd0;
            OP_SELECT: begin
                s.pops = 2'd3;
                s.pushes = 1'b1;
            end
            default: s.known = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/wasm_stack_machine_step_core.sv
// Top level: one WebAssembly instruction step per request on a memory-backed stack machine.
//
// Input channel s_*: one request carries an opcode byte and a 64-bit immediate for the
// slot at the current program counter. Result channel m_*: one result per request with
// the next pc, a status code, the top of the value stack and the stack depth.
// Configuration: cfg_wr_en writes cfg_wr_data to code_length (index 0) or memory_size_bytes
// (index 1); the user must do so only while no request is in flight, the core does not check.
// Sequence: a request is taken in S_IDLE, the second stack operand is captured in S_RDB,
// and the step executes in S_EXEC; the result register fills as S_EXEC ends.
// Most instructions end there; S_RDB covers the value-stack RAM read latency (two operand
// reads in series). Loads and stores go on in S_MEM, which moves the bytes of linear
// memory in turn (1 or 4); div_s and rem_s wait in S_DIV for the serial divider.
// One request is in flight at a time; s_tready is high only when the core is idle and
// the result register is empty or being taken, so a stalled receiver holds the result
// and stops new requests. Reset clears pc, stack pointers, locals, globals, the halt
// flag and restores both configuration registers to 65536; no clearing pass is needed.
module wasm_stack_machine_step_core
    import wsm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,      // command, immediate
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,      // next_pc, status, top_value, stack_depth, zero pad
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_index,
    input  logic [CFG_W-1:0]  cfg_wr_data
);

    state_t state_reg, state_next;

    logic [CMD_W-1:0] op_reg;
    logic [IMM_W-1:0] imm_reg;
    logic [VAL_W-1:0] b_reg;
    logic [PC_W-1:0]  pc_reg;
    logic [SP_W-1:0]  sp_reg;
    logic [LSP_W-1:0] lsp_reg;
    logic [VAL_W-1:0] top_reg;
    logic             halted_reg;
    logic [CFG_W-1:0] code_len_reg;
    logic [CFG_W-1:0] msize_reg;
    logic [VAL_W-1:0] globals_reg [GLOBAL_COUNT];
    logic [PC_W-1:0]  labels_reg [LABEL_DEPTH];
    logic [LOCAL_COUNT-1:0] loc_valid_reg;
    commit_t          plan_reg;
    logic [MA_W-1:0]  ea_reg;
    logic [2:0]       mcnt_reg;
    logic [31:0]      ld_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic             accept;
    logic [CMD_W-1:0] in_cmd;
    logic [IMM_W-1:0] in_imm;

    logic             stk_rd_en;
    logic [SA_W-1:0]  stk_rd_addr;
    logic [VAL_W-1:0] stk_rdata;
    logic             stk_wr_en;
    logic [SA_W-1:0]  stk_wr_addr;
    logic [VAL_W-1:0] loc_rdata;
    logic             loc_wr_en;
    logic             mem_rd_en;
    logic             mem_wr_en;
    logic [MA_W-1:0]  mem_addr;
    logic [7:0]       mem_wr_data;
    logic [7:0]       mem_rdata;

    commit_t          e_cm;
    commit_t          cm;
    logic             e_div;
    logic             e_mem;
    logic             e_lbl_we;
    logic [PC_W-1:0]  e_lbl_val;
    logic             e_loc_we;
    logic             e_glb_we;
    logic [MA_W-1:0]  e_ea;
    logic             fin;
    logic [VAL_W-1:0] top_new;

    logic             div_done;
    logic [31:0]      div_q;
    logic [31:0]      div_r;

    logic             is_load;
    logic [2:0]       mem_n;
    logic [31:0]      ld_now;
    logic [1:0]       ld_idx;
    logic [SP_W-1:0]  sp_m2;
    logic [SP_W-1:0]  sp_m3;

    assign in_cmd = s_tdata[CMD_W-1:0];
    assign in_imm = s_tdata[CMD_W+IMM_W-1:CMD_W];
    assign accept = s_tvalid && s_tready;
    assign sp_m2  = sp_reg - SP_W'(2);
    assign sp_m3  = sp_reg - SP_W'(3);

    assign is_load = (op_reg == OP_LOAD32) || (op_reg == OP_LOAD8_S) || (op_reg == OP_LOAD8_U);
    assign mem_n   = ((op_reg == OP_LOAD32) || (op_reg == OP_STORE32)) ? 3'd4 : 3'd1;

    wsm_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (top_new),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rdata)
    );

    wsm_ram #(.WIDTH(VAL_W), .DEPTH(LOCAL_COUNT)) u_locals (
        .aclk    (aclk),
        .wr_en   (loc_wr_en),
        .wr_addr (imm_reg[LI_W-1:0]),
        .wr_data (top_reg),
        .rd_en   (accept),
        .rd_addr (in_imm[LI_W-1:0]),
        .rd_data (loc_rdata)
    );

    wsm_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_linmem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rdata)
    );

    wsm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (state_reg == S_EXEC && e_div),
        .dividend  (b_reg[31:0]),
        .divisor   (top_reg[31:0]),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // execute stage
    always_comb begin
        shape_t           sh;
        logic [SP_W:0]    nsp;
        logic [31:0]      a32;
        logic [31:0]      b32;
        logic [31:0]      base;
        logic [PC_W-1:0]  npc;
        logic [LIM_W-1:0] lim;
        logic [33:0]      ea_full;
        logic             mem_fail;
        logic [LSP_W-1:0] br_lsp;
        logic [VAL_W-1:0] res;
        commit_t          keep;

        sh   = op_shape(op_reg);
        a32  = top_reg[31:0];
        b32  = b_reg[31:0];
        npc  = pc_reg + PC_W'(1);
        nsp  = {1'b0, sp_reg} + (SP_W+1)'(sh.pushes) - (SP_W+1)'(sh.pops);
        lim  = (LIM_W'(msize_reg) > LIM_W'(MEMORY_BYTES)) ? LIM_W'(MEMORY_BYTES)
                                                            : LIM_W'(msize_reg);
        base = ((op_reg == OP_STORE32) || (op_reg == OP_STORE8)) ? b32 : a32;
        ea_full  = {2'b00, base} + 34'(imm_reg[LIM_W-1:0]);
        mem_fail = (imm_reg > IMM_W'(lim)) || (ea_full + 34'(mem_n) > 34'(lim));
        br_lsp   = lsp_reg - LSP_W'(1) - imm_reg[LSP_W-1:0];
        res      = '0;

        keep = '{pc: pc_reg, st: STAT_RUN, sp: sp_reg, lsp: lsp_reg, push: 1'b0,
                 res: '0, top: top_reg, halt: halted_reg};
        e_cm      = keep;
        e_div     = 1'b0;
        e_mem     = 1'b0;
        e_lbl_we  = 1'b0;
        e_lbl_val = npc + imm_reg[PC_W-1:0];
        e_loc_we  = 1'b0;
        e_glb_we  = 1'b0;
        e_ea      = ea_full[MA_W-1:0];

        if (halted_reg || pc_reg >= code_len_reg) begin
            e_cm.st   = STAT_DONE;
            e_cm.halt = 1'b1;
        end else if (!sh.known) begin
            e_cm.st   = STAT_UNK;
            e_cm.halt = 1'b1;
        end else if (sp_reg < SP_W'(sh.pops) || nsp > (SP_W+1)'(STACK_DEPTH)) begin
            e_cm.st   = STAT_STACK;
            e_cm.halt = 1'b1;
        end else begin
            e_cm.pc   = npc;
            e_cm.sp   = nsp[SP_W-1:0];
            e_cm.push = sh.pushes;
            case (sh.pops)
                2'd1:    e_cm.top = b_reg;
                2'd2:    e_cm.top = stk_rdata;
                default: e_cm.top = top_reg;
            endcase
            case (op_reg)
                OP_EQ:        res = VAL_W'(b32 == a32);
                OP_NE:        res = VAL_W'(b32 != a32);
                OP_LT_S:      res = VAL_W'($signed(b32) < $signed(a32));
                OP_LT_U:      res = VAL_W'(b32 < a32);
                OP_GT_S:      res = VAL_W'($signed(b32) > $signed(a32));
                OP_GT_U:      res = VAL_W'(b32 > a32);
                OP_LE_S:      res = VAL_W'($signed(b32) <= $signed(a32));
                OP_LE_U:      res = VAL_W'(b32 <= a32);
                OP_ADD:       res = sx32(b32 + a32);
                OP_SUB:       res = sx32(b32 - a32);
                OP_MUL:       res = sx32(b32 * a32);
                OP_AND:       res = sx32(b32 & a32);
                OP_OR:        res = sx32(b32 | a32);
                OP_SHL:       res = sx32(b32 << a32[4:0]);
                OP_SHR_S:     res = sx32(32'($signed(b32) >>> a32[4:0]));
                OP_DIV_S, OP_REM_S: begin
                    if (a32 == 32'd0) begin
                        e_cm = keep;
                        e_cm.st = STAT_DIV;
                        e_cm.halt = 1'b1;
                    end else if (b32 == 32'h8000_0000 && a32 == 32'hFFFF_FFFF) begin
                        if (op_reg == OP_DIV_S) begin
                            e_cm = keep;
                            e_cm.st = STAT_DIV;
                            e_cm.halt = 1'b1;
                        end
                    end else begin
                        e_div = 1'b1;
                    end
                end
                OP_I32_CONST: res = sx32(imm_reg[31:0]);
                OP_I64_CONST: res = imm_reg;
                OP_LOCAL_GET: begin
                    if (imm_reg < IMM_W'(LOCAL_COUNT) && loc_valid_reg[imm_reg[LI_W-1:0]]) begin
                        res = loc_rdata;
                    end
                end
                OP_GLOBAL_GET: begin
                    if (imm_reg < IMM_W'(GLOBAL_COUNT)) begin
                        res = globals_reg[imm_reg[GI_W-1:0]];
                    end
                end
                OP_LOCAL_SET: e_loc_we = imm_reg < IMM_W'(LOCAL_COUNT);
                OP_LOCAL_TEE: begin
                    e_loc_we = imm_reg < IMM_W'(LOCAL_COUNT);
                    res = top_reg;
                end
                OP_GLOBAL_SET: e_glb_we = imm_reg < IMM_W'(GLOBAL_COUNT);
                OP_EQZ:       res = VAL_W'(a32 == 32'd0);
                OP_LOAD32, OP_LOAD8_S, OP_LOAD8_U, OP_STORE32, OP_STORE8: begin
                    if (mem_fail) begin
                        e_cm = keep;
                        e_cm.st = STAT_MEM;
                        e_cm.halt = 1'b1;
                    end else begin
                        e_mem = 1'b1;
                    end
                end
                OP_BLOCK, OP_LOOP: begin
                    if (lsp_reg >= LSP_W'(LABEL_DEPTH)) begin
                        e_cm = keep;
                        e_cm.st = STAT_STACK;
                        e_cm.halt = 1'b1;
                    end else begin
                        e_lbl_we = 1'b1;
                        if (op_reg == OP_LOOP) begin
                            e_lbl_val = pc_reg;
                        end
                        e_cm.lsp = lsp_reg + LSP_W'(1);
                    end
                end
                OP_IF: begin
                    if (a32 != 32'd0) begin
                        if (lsp_reg >= LSP_W'(LABEL_DEPTH)) begin
                            e_cm = keep;
                            e_cm.st = STAT_STACK;
                            e_cm.halt = 1'b1;
                        end else begin
                            e_lbl_we = 1'b1;
                            e_cm.lsp = lsp_reg + LSP_W'(1);
                        end
                    end else begin
                        e_cm.pc = npc + imm_reg[PC_W-1:0];
                    end
                end
                OP_BR, OP_BR_IF: begin
                    if (op_reg == OP_BR_IF && a32 == 32'd0) begin
                        e_cm.lsp = lsp_reg;
                    end else if (imm_reg >= IMM_W'(lsp_reg)) begin
                        e_cm = keep;
                        e_cm.st = STAT_STACK;
                        e_cm.halt = 1'b1;
                    end else begin
                        e_cm.pc  = labels_reg[br_lsp[LA_W-1:0]];
                        e_cm.lsp = br_lsp;
                    end
                end
                OP_SELECT:    res = (a32 != 32'd0) ? stk_rdata : b_reg;
                OP_END: begin
                    if (lsp_reg == '0) begin
                        e_cm.halt = 1'b1;
                        e_cm.st = STAT_DONE;
                    end else begin
                        e_cm.lsp = lsp_reg - LSP_W'(1);
                    end
                end
                default:      res = '0;
            endcase
            e_cm.res = res;
        end
    end

    // completion select
    always_comb begin
        ld_idx = 2'(mcnt_reg - 3'd1);
        ld_now = ld_reg;
        ld_now[{ld_idx, 3'b000} +: 8] = mem_rdata;
        fin = 1'b0;
        cm  = plan_reg;
        case (state_reg)
            S_EXEC: begin
                fin = !(e_div || e_mem);
                cm  = e_cm;
            end
            S_DIV: begin
                fin = div_done;
                cm.res = sx32((op_reg == OP_REM_S) ? div_r : div_q);
            end
            S_MEM: begin
                if (is_load) begin
                    fin = (mcnt_reg == mem_n);
                    case (op_reg)
                        OP_LOAD32:  cm.res = sx32(ld_now);
                        OP_LOAD8_S: cm.res = {{(VAL_W-8){ld_now[7]}}, ld_now[7:0]};
                        default:    cm.res = VAL_W'(ld_now[7:0]);
                    endcase
                end else begin
                    fin = (mcnt_reg == mem_n - 3'd1);
                end
            end
            default: fin = 1'b0;
        endcase
        top_new = cm.push ? cm.res : cm.top;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_RDB;
            S_RDB:  state_next = S_EXEC;
            S_EXEC: begin
                if (e_div) begin
                    state_next = S_DIV;
                end else if (e_mem) begin
                    state_next = S_MEM;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:  if (fin) state_next = S_IDLE;
            S_MEM:  if (fin) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
        stk_rd_en   = accept || (state_reg == S_RDB);
        stk_rd_addr = (state_reg == S_RDB) ? sp_m3[SA_W-1:0] : sp_m2[SA_W-1:0];
        stk_wr_en   = fin && cm.push;
        stk_wr_addr = SA_W'(cm.sp - SP_W'(1));
        loc_wr_en   = (state_reg == S_EXEC) && e_loc_we;
        mem_addr    = ea_reg + MA_W'(mcnt_reg);
        mem_rd_en   = (state_reg == S_MEM) && is_load && (mcnt_reg < mem_n);
        mem_wr_en   = (state_reg == S_MEM) && !is_load && (mcnt_reg < mem_n);
        mem_wr_data = top_reg[{mcnt_reg[1:0], 3'b000} +: 8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            sp_reg        <= '0;
            lsp_reg       <= '0;
            halted_reg    <= 1'b0;
            code_len_reg  <= CFG_W'(65536);
            msize_reg     <= CFG_W'(65536);
            loc_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < GLOBAL_COUNT; i++) begin
                globals_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_CODE_LENGTH: code_len_reg <= cfg_wr_data;
                    CFG_MEMORY_SIZE: msize_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (loc_wr_en) begin
                loc_valid_reg[imm_reg[LI_W-1:0]] <= 1'b1;
            end
            if (state_reg == S_EXEC && e_glb_we) begin
                globals_reg[imm_reg[GI_W-1:0]] <= top_reg;
            end
            if (fin) begin
                pc_reg       <= cm.pc;
                sp_reg       <= cm.sp;
                lsp_reg      <= cm.lsp;
                halted_reg   <= cm.halt;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= in_cmd;
            imm_reg <= in_imm;
        end
        if (state_reg == S_RDB) begin
            b_reg <= stk_rdata;
        end
        if (state_reg == S_EXEC) begin
            plan_reg <= e_cm;
            ea_reg   <= e_ea;
            mcnt_reg <= '0;
            if (e_lbl_we) begin
                labels_reg[lsp_reg[LA_W-1:0]] <= e_lbl_val;
            end
        end
        if (state_reg == S_MEM) begin
            mcnt_reg <= mcnt_reg + 3'd1;
            if (is_load && mcnt_reg != 3'd0) begin
                ld_reg <= ld_now;
            end
        end
        if (fin) begin
            top_reg     <= top_new;
            m_tdata_reg <= OUT_W'({cm.sp, (cm.sp == '0) ? VAL_W'(0) : top_new, cm.st, cm.pc});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hdl/wsm_ram.sv
// Generic simple dual-port RAM with registered read.
module wsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/wsm_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
module wsm_div
    import wsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= '0;
            quo_reg   <= dividend[31] ? 32'(-dividend) : dividend;
            dvs_reg   <= divisor[31] ? 32'(-divisor) : divisor;
            neg_q_reg <= dividend[31] ^ divisor[31];
            neg_r_reg <= dividend[31];
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? 32'(-quo_reg) : quo_reg;
    assign remainder = neg_r_reg ? 32'(-rem_reg) : rem_reg;

endmodule
